FILE: design/vertex_normal_accumulator_unit_assert.svh
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define VNA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define VNA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VNA_ASSERT(label, prop, msg)
`define VNA_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: design/vna_pkg.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Widths, command codes, shared types and the saturating clamp.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int ADDR_BITS    = $clog2(VERTEX_DEPTH);
  localparam int INDEX_BITS   = 10;
  localparam int COORD_BITS   = 18;
  localparam int SUM_BITS     = 44;
  localparam int NORM_BITS    = 16;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int EXT_BITS     = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 2;
  localparam int IN_FIELD_BITS = 3 * INDEX_BITS + 3 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 3 * NORM_BITS;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef logic signed [SUM_BITS-1:0] sum_t;
  typedef logic signed [EXT_BITS-1:0] ext_t;

  typedef struct packed {
    sum_t z;
    sum_t y;
    sum_t x;
  } sum_vec_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } pos_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] x;
    logic signed [NORM_BITS-1:0] y;
    logic signed [NORM_BITS-1:0] z;
    logic                        zero;
  } normal_t;

  localparam ext_t SUM_MAX = {{(EXT_BITS-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam ext_t SUM_MIN = ~SUM_MAX;

  // clamp a wide signed value into the accumulator range
  function automatic sum_t sat_sum(input ext_t v);
    sum_t r;
    if (v > SUM_MAX) begin
      r = SUM_MAX[SUM_BITS-1:0];
    end else if (v < SUM_MIN) begin
      r = SUM_MIN[SUM_BITS-1:0];
    end else begin
      r = v[SUM_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Area-weighted vertex normals over a position RAM and a sum RAM.
// ----------------------------------------------------------------------------
// One command is taken at a time. A position write (cmd 0) also clears that
// vertex's sum. A triangle (cmd 1) does three position reads through the
// single position read port, three cross-product terms on two multipliers,
// then a read and a write-back of each corner's sum in the sum RAM. A normal
// read (cmd 2) runs the normalizer: up to 30 one-bit alignment shifts, 32
// square-root steps and a restoring divide per component, all skipped for a
// zero vector. A result waits in the output register while the next command
// is taken. The RAMs need no clearing pass: every vertex must be written
// before it is used.
module vertex_normal_accumulator_unit import vna_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // vertex_index, corner_b, corner_c, coord_x, coord_y, coord_z
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // cmd
  input  logic [1:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // normal_x, normal_y, normal_z
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // normal_zero
  output logic [0:0]               out_tuser
);

`include "vertex_normal_accumulator_unit_assert.svh"

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PRD    = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_ACC_RD = 9'b000001000,
    S_ACC_WR = 9'b000010000,
    S_NRD    = 9'b000100000,
    S_NSTART = 9'b001000000,
    S_NWAIT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  // input fields
  logic [INDEX_BITS-1:0] in_ia, in_ib, in_ic;
  pos_t                  in_pos;
  logic                  in_xfer;

  assign in_ia    = in_tdata[INDEX_BITS-1:0];
  assign in_ib    = in_tdata[2*INDEX_BITS-1:INDEX_BITS];
  assign in_ic    = in_tdata[3*INDEX_BITS-1:2*INDEX_BITS];
  assign in_pos.x = in_tdata[3*INDEX_BITS+COORD_BITS-1:3*INDEX_BITS];
  assign in_pos.y = in_tdata[3*INDEX_BITS+2*COORD_BITS-1:3*INDEX_BITS+COORD_BITS];
  assign in_pos.z = in_tdata[3*INDEX_BITS+3*COORD_BITS-1:3*INDEX_BITS+2*COORD_BITS];
  assign in_xfer  = in_tvalid && in_tready;

  logic ia_ok, ib_ok, ic_ok;
  assign ia_ok = (32'(in_ia) < 32'(VERTEX_DEPTH));
  assign ib_ok = (32'(in_ib) < 32'(VERTEX_DEPTH));
  assign ic_ok = (32'(in_ic) < 32'(VERTEX_DEPTH));

  state_t                        state_r;
  logic [1:0]                    cnt_r;
  logic [ADDR_BITS-1:0]          ia_r, ib_r, ic_r;
  pos_t                          pa_r, pb_r, pc_r;
  logic signed [PROD_BITS-1:0]   prod_a_r, prod_b_r;
  sum_t                          nx_r, ny_r, nz_r;
  logic                          oor_r;
  logic                          out_valid_r;
  normal_t                       out_r;

  // RAM ports
  logic                  pos_we, pos_re;
  logic [ADDR_BITS-1:0]  pos_waddr, pos_raddr;
  pos_t                  pos_rdata;
  logic                  sum_we, sum_re;
  logic [ADDR_BITS-1:0]  sum_waddr, sum_raddr;
  sum_vec_t              sum_wdata, sum_rdata;

  // normalizer
  logic    norm_start, norm_busy, norm_done;
  normal_t norm_res;
  logic    out_load;

  // corner chosen by the step counter
  logic [ADDR_BITS-1:0] corner;
  always_comb begin
    case (cnt_r)
      2'd0:    corner = ia_r;
      2'd1:    corner = ib_r;
      default: corner = ic_r;
    endcase
  end

  // edge vectors and cross-product operands
  logic signed [DIFF_BITS-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [DIFF_BITS-1:0] op_a1, op_a2, op_b1, op_b2;
  assign ux = DIFF_BITS'(pb_r.x) - DIFF_BITS'(pa_r.x);
  assign uy = DIFF_BITS'(pb_r.y) - DIFF_BITS'(pa_r.y);
  assign uz = DIFF_BITS'(pb_r.z) - DIFF_BITS'(pa_r.z);
  assign vx = DIFF_BITS'(pc_r.x) - DIFF_BITS'(pa_r.x);
  assign vy = DIFF_BITS'(pc_r.y) - DIFF_BITS'(pa_r.y);
  assign vz = DIFF_BITS'(pc_r.z) - DIFF_BITS'(pa_r.z);

  always_comb begin
    case (cnt_r)
      2'd0: begin
        op_a1 = uy; op_a2 = vz; op_b1 = uz; op_b2 = vy;
      end
      2'd1: begin
        op_a1 = uz; op_a2 = vx; op_b1 = ux; op_b2 = vz;
      end
      default: begin
        op_a1 = ux; op_a2 = vy; op_b1 = uy; op_b2 = vx;
      end
    endcase
  end

  // saturated difference of the two registered terms
  sum_t cross_term;
  assign cross_term = sat_sum(ext_t'(sat_sum(ext_t'(prod_a_r))) -
                              ext_t'(sat_sum(ext_t'(prod_b_r))));

  // saturated accumulate for the corner being written back
  sum_vec_t acc_new;
  assign acc_new.x = sat_sum(ext_t'(sum_rdata.x) + ext_t'(nx_r));
  assign acc_new.y = sat_sum(ext_t'(sum_rdata.y) + ext_t'(ny_r));
  assign acc_new.z = sat_sum(ext_t'(sum_rdata.z) + ext_t'(nz_r));

  // RAM control
  always_comb begin
    pos_we     = 1'b0;
    pos_waddr  = ADDR_BITS'(in_ia);
    pos_re     = 1'b0;
    pos_raddr  = corner;
    sum_we     = 1'b0;
    sum_waddr  = corner;
    sum_wdata  = acc_new;
    sum_re     = 1'b0;
    sum_raddr  = corner;
    norm_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (cmd_t'(in_tuser) == CMD_WRITE) && ia_ok) begin
          pos_we    = 1'b1;
          sum_we    = 1'b1;
          sum_waddr = ADDR_BITS'(in_ia);
          sum_wdata = '0;
        end
      end
      S_PRD:    pos_re = (cnt_r != 2'd3);
      S_ACC_RD: sum_re = 1'b1;
      S_ACC_WR: sum_we = 1'b1;
      S_NRD: begin
        sum_re    = 1'b1;
        sum_raddr = ia_r;
      end
      S_NSTART: norm_start = 1'b1;
      default: ;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      oor_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          ia_r  <= ADDR_BITS'(in_ia);
          ib_r  <= ADDR_BITS'(in_ib);
          ic_r  <= ADDR_BITS'(in_ic);
          if (in_xfer) begin
            case (cmd_t'(in_tuser))
              CMD_TRI: begin
                if (ia_ok && ib_ok && ic_ok) state_r <= S_PRD;
              end
              CMD_READ: begin
                oor_r   <= !ia_ok;
                state_r <= ia_ok ? S_NRD : S_OUT;
              end
              default: ;
            endcase
          end
        end
        // read the three corner positions
        S_PRD: begin
          case (cnt_r)
            2'd1:    pa_r <= pos_rdata;
            2'd2:    pb_r <= pos_rdata;
            2'd3:    pc_r <= pos_rdata;
            default: ;
          endcase
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= S_MUL;
        end
        // one cross-product component a cycle, two multipliers
        S_MUL: begin
          prod_a_r <= op_a1 * op_a2;
          prod_b_r <= op_b1 * op_b2;
          case (cnt_r)
            2'd1:    nx_r <= cross_term;
            2'd2:    ny_r <= cross_term;
            2'd3:    nz_r <= cross_term;
            default: ;
          endcase
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= S_ACC_RD;
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        // write back; next read starts after this write lands
        S_ACC_WR: begin
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 2'd1;
            state_r <= S_ACC_RD;
          end
        end
        S_NRD:    state_r <= S_NSTART;
        S_NSTART: state_r <= S_NWAIT;
        S_NWAIT: begin
          if (norm_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            oor_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= oor_r ? '{x: '0, y: '0, z: '0, zero: 1'b1} : norm_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.z, out_r.y, out_r.x};
  assign out_tuser  = out_r.zero;

  vna_ram #(
    .WIDTH ($bits(pos_t)),
    .DEPTH (VERTEX_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (in_pos),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(
    .WIDTH ($bits(sum_vec_t)),
    .DEPTH (VERTEX_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  vna_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .sum_in (sum_rdata),
    .busy   (norm_busy),
    .done   (norm_done),
    .result (norm_res)
  );

  // write-back always follows its own read
  `VNA_ASSERT(a_acc_order, (state_r == S_ACC_WR) |-> ($past(state_r) == S_ACC_RD), "sum write-back without read")
  // normalizer is never restarted mid-run
  `VNA_ASSERT_NEVER(a_norm_restart, norm_start && norm_busy, "normalizer started while busy")
  // a pending result is never overwritten
  `VNA_ASSERT(a_out_hold, out_load |-> (!out_valid_r || out_tready), "output overwritten")

endmodule

FILE: design/vna_ram.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/vna_norm.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator normalizer
// Scales an accumulated vector to unit length: bit-serial alignment,
// squared length, restoring square root and restoring divide per component.
// ----------------------------------------------------------------------------
module vna_norm import vna_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  sum_vec_t sum_in,
  output logic     busy,
  output logic     done,
  output normal_t  result
);

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_CHECK = 7'b0000010,
    N_SHIFT = 7'b0000100,
    N_SQ    = 7'b0001000,
    N_SQRT  = 7'b0010000,
    N_DSET  = 7'b0100000,
    N_DIV   = 7'b1000000
  } nstate_t;

  nstate_t             state_r;
  logic [SUM_BITS-1:0] mag_r [3];
  logic [2:0]          neg_r;
  logic [4:0]          cnt_r;
  logic [1:0]          comp_r;
  logic [61:0]         sq_r;
  logic [63:0]         l2_r;
  logic [63:0]         v_r;
  logic [63:0]         root_r;
  logic [63:0]         bit_r;
  logic [49:0]         num_r;
  logic [49:0]         den_r;
  logic [15:0]         q_r;
  logic                done_r;
  normal_t             res_r;

  logic [SUM_BITS-1:0] mag_or;
  logic                mag_hi;
  logic [30:0]         mag_sel;
  logic [31:0]         len;
  logic [63:0]         trial;
  logic                q_bit;
  logic [16:0]         q_fin;
  logic [NORM_BITS-1:0] comp_val;

  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];
  assign mag_hi = |mag_or[SUM_BITS-1:31];
  assign len    = root_r[31:0];
  assign trial  = root_r + bit_r;
  assign q_bit  = (num_r >= den_r);
  assign q_fin  = {q_r, q_bit};

  // component picked for squaring and dividing
  always_comb begin
    case (state_r)
      N_SQ:    mag_sel = (cnt_r[1:0] == 2'd3) ? 31'd0 : mag_r[cnt_r[1:0]][30:0];
      default: mag_sel = (comp_r == 2'd3) ? 31'd0 : mag_r[comp_r][30:0];
    endcase
  end

  // clamp the quotient and apply the sign
  always_comb begin
    logic neg;
    neg = 1'b0;
    case (comp_r)
      2'd0:    neg = neg_r[0];
      2'd1:    neg = neg_r[1];
      2'd2:    neg = neg_r[2];
      default: neg = 1'b0;
    endcase
    if (neg) begin
      comp_val = (q_fin > 17'd32768) ? 16'h8000 : 16'(~q_fin + 17'd1);
    end else begin
      comp_val = (q_fin > 17'd32767) ? 16'h7fff : q_fin[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            neg_r    <= {sum_in.z[SUM_BITS-1], sum_in.y[SUM_BITS-1], sum_in.x[SUM_BITS-1]};
            mag_r[0] <= sum_in.x[SUM_BITS-1] ? -sum_in.x : sum_in.x;
            mag_r[1] <= sum_in.y[SUM_BITS-1] ? -sum_in.y : sum_in.y;
            mag_r[2] <= sum_in.z[SUM_BITS-1] ? -sum_in.z : sum_in.z;
            state_r  <= N_CHECK;
          end
        end
        N_CHECK: begin
          if (mag_or == '0) begin
            res_r   <= '{x: '0, y: '0, z: '0, zero: 1'b1};
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end else begin
            state_r <= N_SHIFT;
          end
        end
        // one bit a cycle until the largest magnitude has its top bit at 30
        N_SHIFT: begin
          if (mag_hi) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else if (!mag_or[30]) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
          end else begin
            cnt_r   <= '0;
            l2_r    <= '0;
            state_r <= N_SQ;
          end
        end
        // squared length, one square a cycle
        N_SQ: begin
          sq_r <= 62'(mag_sel) * 62'(mag_sel);
          if (cnt_r != 5'd0) begin
            l2_r <= l2_r + 64'(sq_r);
          end
          if (cnt_r == 5'd3) begin
            v_r     <= l2_r + 64'(sq_r);
            root_r  <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= N_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        // floor square root, one result bit a cycle
        N_SQRT: begin
          if (v_r >= trial) begin
            v_r    <= v_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            comp_r  <= '0;
            state_r <= N_DSET;
          end
        end
        N_DSET: begin
          num_r   <= 50'({mag_sel, 16'd0}) + 50'(len);
          den_r   <= 50'(len) << 17;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        // round(mag * 32768 / len), one quotient bit a cycle
        N_DIV: begin
          if (q_bit) begin
            num_r <= num_r - den_r;
          end
          den_r <= den_r >> 1;
          q_r   <= q_fin[15:0];
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            case (comp_r)
              2'd0:    res_r.x <= comp_val;
              2'd1:    res_r.y <= comp_val;
              default: res_r.z <= comp_val;
            endcase
            res_r.zero <= 1'b0;
            if (comp_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= N_DSET;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign busy   = (state_r != N_IDLE);
  assign done   = done_r;
  assign result = res_r;

endmodule
